>>> rtl/vumbar_pkg.sv
// Package of the multichannel VU meter bar driver: field widths, reset values
// of the per-channel state and of the registers, and the register index codes.
// No dependencies; used by the top level and by its checker.
package vumbar_pkg;

  // Input request fields.
  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 8;
  localparam int IN_TDATA_W = 16;

  // Per-channel state.
  localparam int MEAN_W  = 16;
  localparam int LEVEL_W = 24;
  localparam logic [MEAN_W-1:0]  MEAN_RESET  = 16'd65280;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 24'd32512;

  // The integer part of the level divided by 32 drops 8 + 5 low bits.
  localparam int LEVEL_SHIFT = 13;
  localparam int LEVEL_INT_W = LEVEL_W - LEVEL_SHIFT;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_TOP     = 3'd0,
    CFG_GAIN_OTHER   = 3'd1,
    CFG_WEIGHT_FIRST = 3'd2,
    CFG_WEIGHT_OTHER = 3'd3,
    CFG_MEAN_WEIGHT  = 3'd4
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] GAIN_TOP_RESET     = 8'd110;
  localparam logic [CFG_DATA_W-1:0] GAIN_OTHER_RESET   = 8'd65;
  localparam logic [CFG_DATA_W-1:0] WEIGHT_FIRST_RESET = 8'd3;
  localparam logic [CFG_DATA_W-1:0] WEIGHT_OTHER_RESET = 8'd26;
  localparam logic [CFG_DATA_W-1:0] MEAN_WEIGHT_RESET  = 8'd26;

endpackage

>>> rtl/multichannel_vu_meter_bar.sv
// Multichannel VU meter bar driver: per-channel running mean, gained deviation,
// one-pole level smoothing and bar graph encoding over a small state memory.
// Depends on vumbar_pkg.
//
// Input: a new sample is accepted only after the previous one has finished, as set by the
// read-modify-write of the channel's state word through a single memory port and a shared
// sequencer.
// Reset: synchronous, active low; clears the sequencer, the output register and the
// per-channel valid bits (so all channels read as their reset state), and loads the
// register defaults. There is no clearing pass; input is taken right after reset.
module multichannel_vu_meter_bar #(
  parameter int CHANNELS = 5,
  parameter int BAR_LEDS = 8
) (
  input  logic clk,
  input  logic rst_n,

  // in_tdata, from bit 0 up: channel[2:0], sample[7:0], zero padding.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [vumbar_pkg::IN_TDATA_W-1:0]    in_tdata,

  // out_tdata, from bit 0 up: column_select[CHANNELS-1:0], row_bar[BAR_LEDS-1:0],
  // bar_count, zero padding to whole bytes.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((CHANNELS + BAR_LEDS + $clog2(BAR_LEDS + 1) + 7) / 8) * 8 - 1:0] out_tdata,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vumbar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vumbar_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W       = $clog2(BAR_LEDS + 1);
  localparam int OUT_W       = CHANNELS + BAR_LEDS + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WORD_W      = vumbar_pkg::LEVEL_W + vumbar_pkg::MEAN_W;
  localparam int CH_W        = vumbar_pkg::CH_W;
  localparam int MEAN_W      = vumbar_pkg::MEAN_W;
  localparam int LEVEL_W     = vumbar_pkg::LEVEL_W;
  localparam int SAMPLE_W    = vumbar_pkg::SAMPLE_W;
  localparam int LEVEL_INT_W = vumbar_pkg::LEVEL_INT_W;

  localparam logic [CH_W:0]   CH_COUNT = (CH_W + 1)'(CHANNELS);
  localparam logic [CH_W-1:0] CH_TOP   = CH_W'(CHANNELS - 1);
  localparam logic [LEVEL_INT_W-1:0] BAR_MAX = LEVEL_INT_W'(BAR_LEDS);

  // Sequencer: the memory read is issued as the sample is accepted, then the mean, the gained
  // deviation and the level are worked out one per cycle, the level step waiting on a full output.
  typedef enum logic [1:0] {
    S_IDLE,
    S_MEAN,
    S_DEV,
    S_LVL
  } state_t;

  state_t state_r;

  // Registers.
  logic [vumbar_pkg::CFG_DATA_W-1:0] gain_top_r, gain_other_r;
  logic [vumbar_pkg::CFG_DATA_W-1:0] weight_first_r, weight_other_r, mean_weight_r;

  // State memory: each word holds {level, mean} of one channel.
  logic [WORD_W-1:0]   mem [CHANNELS];
  logic [WORD_W-1:0]   rd_word_r;
  logic                rd_valid_r;
  logic [CHANNELS-1:0] valid_r;

  logic [CH_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [LEVEL_W-1:0]  dev_r;

  logic [CHANNELS-1:0] col_r;
  logic [BAR_LEDS-1:0] bar_r;
  logic [CNT_W-1:0]    count_r;
  logic                out_tvalid_r;

  logic [CH_W-1:0]     in_ch;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_take;
  logic                in_good;
  logic                lvl_go;

  logic [MEAN_W-1:0]   old_mean;
  logic [LEVEL_W-1:0]  old_level;

  logic signed [MEAN_W:0]    mean_diff;
  logic signed [MEAN_W+9:0]  mean_prod;
  logic signed [MEAN_W+9:0]  mean_acc;
  logic [MEAN_W-1:0]         mean_nxt;

  logic [MEAN_W-1:0]   s_fix;
  logic [MEAN_W-1:0]   abs_dev;
  logic [vumbar_pkg::CFG_DATA_W-1:0] gain_sel;
  logic [LEVEL_W-1:0]  dev_nxt;

  logic [vumbar_pkg::CFG_DATA_W-1:0] lvl_weight;
  logic signed [LEVEL_W:0]    lvl_diff;
  logic signed [LEVEL_W+9:0]  lvl_prod;
  logic signed [LEVEL_W+9:0]  lvl_acc;
  logic [LEVEL_W-1:0]         level_nxt;

  logic [LEVEL_INT_W-1:0] lvl_int;
  logic [CNT_W-1:0]    count_nxt;
  logic [BAR_LEDS-1:0] bar_nxt;
  logic [CHANNELS-1:0] col_nxt;

  // Input request unpacking and handshake.
  assign in_ch     = in_tdata[CH_W-1:0];
  assign in_sample = in_tdata[CH_W +: SAMPLE_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_take   = in_tvalid && in_tready;
  // A channel beyond the last one is accepted and dropped without a result.
  assign in_good   = ({1'b0, in_ch} < CH_COUNT);

  // The level step finishes only when the output register is free or being emptied.
  assign lvl_go = (state_r == S_LVL) && (!out_tvalid_r || out_tready);

  assign cfg_ready = 1'b1;

  // A channel never written since reset reads as its reset state.
  assign old_mean  = rd_valid_r ? rd_word_r[MEAN_W-1:0] : vumbar_pkg::MEAN_RESET;
  assign old_level = rd_valid_r ? rd_word_r[WORD_W-1:MEAN_W] : vumbar_pkg::LEVEL_RESET;

  // The blend (256 - w) * old + w * fresh is formed as old * 256 + w * (fresh - old),
  // which needs a single multiplier and is exact for every weight including zero.
  assign s_fix     = {sample_r, 8'd0};
  assign mean_diff = $signed({1'b0, s_fix}) - $signed({1'b0, old_mean});
  assign mean_prod = (MEAN_W + 10)'($signed({1'b0, mean_weight_r})) *
                     (MEAN_W + 10)'(mean_diff);
  assign mean_acc  = $signed({2'b00, old_mean, 8'd0}) + mean_prod;
  assign mean_nxt  = mean_acc[MEAN_W+7:8];

  // Absolute deviation from the fresh mean, times the channel's gain.
  assign abs_dev  = (s_fix >= mean_r) ? (s_fix - mean_r) : (mean_r - s_fix);
  assign gain_sel = (ch_r == CH_TOP) ? gain_top_r : gain_other_r;
  assign dev_nxt  = LEVEL_W'(abs_dev) * LEVEL_W'(gain_sel);

  // Level smoothing, channel zero with its own weight.
  assign lvl_weight = (ch_r == '0) ? weight_first_r : weight_other_r;
  assign lvl_diff   = $signed({1'b0, dev_r}) - $signed({1'b0, old_level});
  assign lvl_prod   = (LEVEL_W + 10)'($signed({1'b0, lvl_weight})) *
                      (LEVEL_W + 10)'(lvl_diff);
  assign lvl_acc    = $signed({2'b00, old_level, 8'd0}) + lvl_prod;
  assign level_nxt  = lvl_acc[LEVEL_W+7:8];

  // Bar graph: integer level over 32, saturated, as a thermometer code.
  assign lvl_int   = level_nxt[LEVEL_W-1:vumbar_pkg::LEVEL_SHIFT];
  assign count_nxt = (lvl_int > BAR_MAX) ? CNT_W'(BAR_LEDS) : CNT_W'(lvl_int);

  always_comb begin
    for (int i = 0; i < BAR_LEDS; i++) begin
      bar_nxt[i] = (count_nxt > CNT_W'(i));
    end
    for (int j = 0; j < CHANNELS; j++) begin
      col_nxt[j] = (ch_r == CH_W'(j));
    end
  end

  // State memory port: read on accept, write back when the level step finishes.
  always_ff @(posedge clk) begin
    if (in_take && in_good) begin
      rd_word_r <= mem[in_ch[IDX_W-1:0]];
    end
    if (lvl_go) begin
      mem[ch_r[IDX_W-1:0]] <= {level_nxt, mean_r};
    end
  end

  // Sequencer, valid bits and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      rd_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A finishing level step refills the output register; otherwise the sink
      // empties it.
      if (lvl_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take && in_good) begin
            ch_r       <= in_ch;
            sample_r   <= in_sample;
            rd_valid_r <= valid_r[in_ch[IDX_W-1:0]];
            state_r    <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean_r  <= mean_nxt;
          state_r <= S_DEV;
        end
        S_DEV: begin
          dev_r   <= dev_nxt;
          state_r <= S_LVL;
        end
        S_LVL: begin
          if (lvl_go) begin
            valid_r[ch_r[IDX_W-1:0]] <= 1'b1;
            col_r        <= col_nxt;
            bar_r        <= bar_nxt;
            count_r      <= count_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_top_r     <= vumbar_pkg::GAIN_TOP_RESET;
      gain_other_r   <= vumbar_pkg::GAIN_OTHER_RESET;
      weight_first_r <= vumbar_pkg::WEIGHT_FIRST_RESET;
      weight_other_r <= vumbar_pkg::WEIGHT_OTHER_RESET;
      mean_weight_r  <= vumbar_pkg::MEAN_WEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (vumbar_pkg::cfg_idx_t'(cfg_index))
        vumbar_pkg::CFG_GAIN_TOP:     gain_top_r     <= cfg_data;
        vumbar_pkg::CFG_GAIN_OTHER:   gain_other_r   <= cfg_data;
        vumbar_pkg::CFG_WEIGHT_FIRST: weight_first_r <= cfg_data;
        vumbar_pkg::CFG_WEIGHT_OTHER: weight_other_r <= cfg_data;
        vumbar_pkg::CFG_MEAN_WEIGHT:  mean_weight_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({count_r, bar_r, col_r});

endmodule

>>> rtl/vumbar_checker.sv
// Port-level checker of the multichannel VU meter bar driver, with its bind.
// Depends on vumbar_pkg and on the top level multichannel_vu_meter_bar.
module vumbar_checker #(
  parameter int CHANNELS = 5,
  parameter int BAR_LEDS = 8
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [vumbar_pkg::IN_TDATA_W-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((CHANNELS + BAR_LEDS + $clog2(BAR_LEDS + 1) + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int CNT_W = $clog2(BAR_LEDS + 1);
  localparam int CH_W  = vumbar_pkg::CH_W;
  localparam logic [CH_W:0] CH_COUNT = (CH_W + 1)'(CHANNELS);

  logic [CHANNELS-1:0] col;
  logic [BAR_LEDS-1:0] bar;
  logic [CNT_W-1:0]    count;
  logic [BAR_LEDS-1:0] bar_exp;
  logic                in_good;

  assign col     = out_tdata[CHANNELS-1:0];
  assign bar     = out_tdata[CHANNELS +: BAR_LEDS];
  assign count   = out_tdata[CHANNELS + BAR_LEDS +: CNT_W];
  assign in_good = ({1'b0, in_tdata[CH_W-1:0]} < CH_COUNT);

  always_comb begin
    for (int i = 0; i < BAR_LEDS; i++) begin
      bar_exp[i] = (count > CNT_W'(i));
    end
  end

  // A result waiting for the sink holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A sample of a real channel keeps the input closed while it is worked on.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_good |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input taken while a sample is in progress");

  // Column drive is one-hot, the count is at most BAR_LEDS, and the bar is the thermometer code of its count.
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(col) && (count <= CNT_W'(BAR_LEDS)))
    else $error("bad column select or count");

  a_bar: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> bar == bar_exp)
    else $error("bar does not match its count");

endmodule

bind multichannel_vu_meter_bar vumbar_checker #(
  .CHANNELS(CHANNELS),
  .BAR_LEDS(BAR_LEDS)
) u_vumbar_checker (.*);
